// ===== sv/breakpoint_watchpoint_unit_macros.svh =====
// assertion macros shared by the debug match unit
`ifndef BREAKPOINT_WATCHPOINT_UNIT_MACROS_SVH
`define BREAKPOINT_WATCHPOINT_UNIT_MACROS_SVH

// same-cycle implication, held off while reset is active
`define BWU_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is active
`define BWU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bwu_pkg.sv =====
// shared codes and sizes for the debug match unit
`default_nettype none

package bwu_pkg;

    // default slot count of each address table
    localparam int TABLE_DEPTH_DEF = 8;
    // execute, read watch and write watch tables
    localparam int NUM_TABLES = 3;
    localparam int ADDR_W     = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_EXEC  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NOOP = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== sv/breakpoint_watchpoint_unit.sv =====
// Debug address match unit: execute breakpoint, read watch and write watch tables.
// Each item adds, deletes or checks a 32-bit address in one of three tables of
// TABLE_DEPTH slots; every slot of the selected table is compared in parallel.
// The unit takes one item per cycle and returns one result per item: the input register
// takes the item at the accepting edge and the result register takes it when the result
// slot frees; the table update of an item is visible to the item right behind it.
// Back-pressure on the result side stalls the input side once both registers are full.
`default_nettype none
`include "breakpoint_watchpoint_unit_macros.svh"

module breakpoint_watchpoint_unit
    import bwu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] address
    input  wire logic [3:0]  s_tuser,   // [1:0] op, [3:2] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] triggered, [2:1] status, [7:3] zero
);

    // input stage
    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic [1:0]        in_kind_reg;
    logic [ADDR_W-1:0] in_addr_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_trig_reg;
    logic [1:0]        out_status_reg;

    // address tables and their valid bits
    logic [NUM_TABLES-1:0][TABLE_DEPTH-1:0][ADDR_W-1:0] addr_reg;
    logic [NUM_TABLES-1:0][TABLE_DEPTH-1:0]             valid_reg;
    logic [NUM_TABLES-1:0][TABLE_DEPTH-1:0]             valid_next;

    logic                                   advance;
    logic                                   kind_ok;
    logic [TABLE_DEPTH-1:0]                 sel_valid;
    logic [TABLE_DEPTH-1:0][ADDR_W-1:0]     sel_addr;
    logic [TABLE_DEPTH-1:0]                 hit_vec;
    logic [TABLE_DEPTH-1:0]                 free_vec;
    logic [TABLE_DEPTH-1:0]                 first_free;
    logic [TABLE_DEPTH-1:0]                 sel_valid_next;
    logic                                   do_write;
    logic                                   trig_next;
    logic [1:0]                             status_next;

    // item moves from input stage to result stage when the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_trig_reg};

    // table select
    always_comb begin
        kind_ok   = 1'b0;
        sel_valid = '0;
        sel_addr  = '0;
        unique case (in_kind_reg)
            KIND_EXEC, KIND_READ, KIND_WRITE: begin
                kind_ok   = 1'b1;
                sel_valid = valid_reg[in_kind_reg];
                sel_addr  = addr_reg[in_kind_reg];
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
    end

    // parallel compare and lowest free slot
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_vec[i] = sel_valid[i] && (sel_addr[i] == in_addr_reg);
        end
        free_vec   = ~sel_valid;
        first_free = free_vec & (~free_vec + TABLE_DEPTH'(1));
    end

    // operation decode
    always_comb begin
        trig_next      = 1'b0;
        status_next    = ST_NOOP;
        do_write       = 1'b0;
        sel_valid_next = sel_valid;
        if (kind_ok) begin
            unique case (in_op_reg)
                OP_ADD: begin
                    if (|hit_vec) begin
                        status_next = ST_NOOP;
                    end else if (|free_vec) begin
                        status_next    = ST_DONE;
                        do_write       = 1'b1;
                        sel_valid_next = sel_valid | first_free;
                    end else begin
                        status_next = ST_FULL;
                    end
                end
                OP_DEL: begin
                    if (|hit_vec) begin
                        status_next    = ST_DONE;
                        sel_valid_next = sel_valid & ~hit_vec;
                    end else begin
                        status_next = ST_NOOP;
                    end
                end
                OP_CHECK: begin
                    trig_next   = |hit_vec;
                    status_next = ST_DONE;
                end
                default: begin
                    status_next = ST_NOOP;
                end
            endcase
        end
    end

    // valid bit update for the selected table
    always_comb begin
        valid_next = valid_reg;
        for (int t = 0; t < NUM_TABLES; t++) begin
            if (advance && kind_ok && (in_kind_reg == 2'(t))) begin
                valid_next[t] = sel_valid_next;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            valid_reg <= valid_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser[1:0];
            in_kind_reg <= s_tuser[3:2];
            in_addr_reg <= s_tdata;
        end
        if (advance) begin
            out_trig_reg   <= trig_next;
            out_status_reg <= status_next;
        end
        // store a new address in the lowest free slot
        for (int t = 0; t < NUM_TABLES; t++) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (advance && do_write && (in_kind_reg == 2'(t)) && first_free[i]) begin
                    addr_reg[t][i] <= in_addr_reg;
                end
            end
        end
    end

    // a table never holds one address twice
    `BWU_ASSERT_SAME(a_no_dup_hit, aclk, aresetn, in_valid_reg, $onehot0(hit_vec),
        "address matches more than one slot")
    // a check leaves every table unchanged
    `BWU_ASSERT_NEXT(a_check_keeps_tables, aclk, aresetn,
        advance && (in_op_reg == OP_CHECK), $stable(valid_reg),
        "check item changed a table")
    // full is only reported when every slot of the table is taken
    `BWU_ASSERT_SAME(a_full_means_full, aclk, aresetn,
        advance && (status_next == ST_FULL), &sel_valid,
        "full reported with a free slot")
    // a trigger always comes with status done
    `BWU_ASSERT_SAME(a_trig_done, aclk, aresetn, out_valid_reg && out_trig_reg,
        out_status_reg == ST_DONE, "trigger without done status")

endmodule

`default_nettype wire

// ===== tb/bwu_result_checker.sv =====
`timescale 1ns / 100ps
// result checker for the debug match unit: shadow address tables and in-order comparison
module bwu_result_checker
    import bwu_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] address
    input  logic [3:0]  s_tuser,    // [1:0] op, [3:2] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [0] triggered, [2:1] status, [7:3] zero
    output int          fail_count,
    output int          results_due,
    output int          hit_count,
    output int          full_count,
    output int          noop_count
);

    typedef struct packed {
        logic    triggered;
        status_t status;
    } match_result_t;

    // shadow copy of the three tables
    logic [ADDR_W-1:0] shadow_addr [NUM_TABLES][DEPTH];
    logic              shadow_used [NUM_TABLES][DEPTH];

    // results still owed by the unit, oldest first
    match_result_t owed_results [$];

    int errors = 0;
    int hits   = 0;
    int fulls  = 0;
    int noops  = 0;

    initial begin
        fail_count  = 0;
        results_due = 0;
        hit_count   = 0;
        full_count  = 0;
        noop_count  = 0;
    end

    // apply one item to the shadow tables and return what the unit should answer
    function automatic match_result_t apply_match_item(logic [1:0] op, logic [1:0] kind,
                                                       logic [31:0] addr);
        match_result_t res;
        int hit;
        int free_slot;
        int i;
        res.triggered = 1'b0;
        res.status    = ST_NOOP;
        hit           = -1;
        free_slot     = -1;
        if (kind <= KIND_WRITE) begin
            // scan downward so the lowest matching and lowest free slots win
            for (i = DEPTH - 1; i >= 0; i--) begin
                if (shadow_used[kind][i] && shadow_addr[kind][i] == addr)
                    hit = i;
                if (!shadow_used[kind][i])
                    free_slot = i;
            end
            case (op)
                OP_ADD: begin
                    if (hit >= 0) begin
                        res.status = ST_NOOP;
                    end else if (free_slot >= 0) begin
                        shadow_addr[kind][free_slot] = addr;
                        shadow_used[kind][free_slot] = 1'b1;
                        res.status = ST_DONE;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                OP_DEL: begin
                    if (hit >= 0) begin
                        shadow_used[kind][hit] = 1'b0;
                        res.status = ST_DONE;
                    end else begin
                        res.status = ST_NOOP;
                    end
                end
                OP_CHECK: begin
                    res.triggered = (hit >= 0);
                    res.status    = ST_DONE;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // predict on each accepted input item, compare on each accepted result item
    always @(posedge aclk) begin : track
        match_result_t want;
        match_result_t fresh;
        if (!aresetn) begin
            for (int t = 0; t < NUM_TABLES; t++)
                for (int s = 0; s < DEPTH; s++)
                    shadow_used[t][s] = 1'b0;
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                fresh        = apply_match_item(s_tuser[1:0], s_tuser[3:2], s_tdata);
                owed_results = {owed_results, fresh};
            end
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[0] !== want.triggered) begin
                        $display("%0t: triggered mismatch, expected %0d, got %0d",
                                 $time, want.triggered, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[2:1] !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, m_tdata[2:1]);
                        errors++;
                    end
                    if (m_tdata[7:3] !== 5'd0) begin
                        $display("%0t: padding mismatch, expected 0, got %h",
                                 $time, m_tdata[7:3]);
                        errors++;
                    end
                    if (want.triggered)
                        hits++;
                    if (want.status == ST_FULL)
                        fulls++;
                    if (want.status == ST_NOOP)
                        noops++;
                end
            end
        end
        fail_count  <= errors;
        results_due <= owed_results.size();
        hit_count   <= hits;
        full_count  <= fulls;
        noop_count  <= noops;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// top of the debug match unit testbench: clock, reset, stimulus, result sink and verdict
module testbench;
    import bwu_pkg::*;

    localparam int         DEPTH        = TABLE_DEPTH_DEF;
    localparam int         RANDOM_ITEMS = 1850;
    localparam int         POOL_SIZE    = 12;
    localparam int         HOLD_AFTER   = 400;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 10;
    // codes the unit must treat as no-ops
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int fail_count;
    int results_due;
    int hit_count;
    int full_count;
    int noop_count;
    int items_sent = 0;

    logic [31:0] addr_pool [NUM_TABLES][POOL_SIZE];

    breakpoint_watchpoint_unit #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    bwu_result_checker #(
        .DEPTH(DEPTH)
    ) match_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .results_due(results_due),
        .hit_count  (hit_count),
        .full_count (full_count),
        .noop_count (noop_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("[breakpoint_watchpoint_unit] ERROR");
        $finish;
    end

    // offer one item, after a random gap except in gap-free stretches, and wait until it is taken
    task automatic send_item(input logic [1:0] op, input logic [1:0] kind,
                             input logic [31:0] addr);
        int gap;
        gap = ((items_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= {kind, op};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // result sink with random stalls, stall-free stretches and one long hold
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == HOLD_AFTER)
                stall = HOLD_CYCLES;
            else
                stall = ((taken / 48) % 3 == 2) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [31:0] addr;
        int          pick;

        for (int t = 0; t < NUM_TABLES; t++)
            for (int p = 0; p < POOL_SIZE; p++)
                addr_pool[t][p] = $urandom;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, duplicates, full table, slot reuse
        send_item(OP_CHECK, KIND_EXEC, 32'h0000_0000);
        send_item(OP_DEL,   KIND_EXEC, 32'h0000_0000);
        send_item(OP_ADD,   KIND_EXEC, 32'h0000_0000);
        send_item(OP_ADD,   KIND_EXEC, 32'hFFFF_FFFF);
        send_item(OP_ADD,   KIND_EXEC, 32'h0000_0000);
        send_item(OP_CHECK, KIND_EXEC, 32'hFFFF_FFFF);
        send_item(OP_CHECK, KIND_READ, 32'hFFFF_FFFF);
        for (int i = 1; i <= DEPTH - 2; i++)
            send_item(OP_ADD, KIND_EXEC, 32'h5A5A_0000 + i);
        send_item(OP_ADD,   KIND_EXEC,  32'h1234_5678);
        send_item(OP_DEL,   KIND_EXEC,  32'h0000_0000);
        send_item(OP_ADD,   KIND_EXEC,  32'h1234_5678);
        send_item(OP_CHECK, KIND_EXEC,  32'h1234_5678);
        // read and write tables kept apart
        send_item(OP_ADD,   KIND_READ,  32'h8000_0000);
        send_item(OP_ADD,   KIND_WRITE, 32'h8000_0000);
        send_item(OP_CHECK, KIND_WRITE, 32'h8000_0000);
        send_item(OP_CHECK, KIND_READ,  32'h7FFF_FFFF);
        // unused op and table codes
        send_item(OP_UNUSED, KIND_EXEC, 32'hFFFF_FFFF);
        send_item(OP_ADD,    KIND_NONE, 32'h8000_0000);
        send_item(OP_CHECK,  KIND_NONE, 32'h8000_0000);
        send_item(OP_DEL,    KIND_WRITE, 32'h8000_0000);

        // random: mostly pooled addresses so tables fill, hit and drain; some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                kind = 2'($urandom_range(0, 2));
                // now and then borrow another table's address to test isolation
                if ($urandom_range(0, 4) == 0)
                    addr = addr_pool[$urandom_range(0, 2)][$urandom_range(0, POOL_SIZE - 1)];
                else
                    addr = addr_pool[kind][$urandom_range(0, POOL_SIZE - 1)];
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = OP_ADD;
                else if (pick < 65)
                    op = OP_DEL;
                else
                    op = OP_CHECK;
            end else begin
                op   = 2'($urandom_range(0, 3));
                kind = 2'($urandom_range(0, 3));
                addr = $urandom;
            end
            send_item(op, kind, addr);
        end
        s_tvalid <= 1'b0;

        // drain
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items over all three tables plus unused codes", items_sent);
        $display("saw %0d hits, %0d full tables, %0d no-ops, one %0d-cycle result hold",
                 hit_count, full_count, noop_count, HOLD_CYCLES);
        if (fail_count == 0)
            $display("[breakpoint_watchpoint_unit] OK");
        else
            $display("[breakpoint_watchpoint_unit] ERROR");
        $finish;
    end

endmodule
